FILE: src/npe_pkg.sv
`default_nettype none

package npe_pkg;

   localparam int DATA_W = 32;

   // one-hot sequencer states
   typedef enum logic [10:0] {
      ST_LOAD      = 11'b000_0000_0001,
      ST_ASC_RD    = 11'b000_0000_0010,
      ST_ASC_CMP   = 11'b000_0000_0100,
      ST_J_RD      = 11'b000_0000_1000,
      ST_J_CMP     = 11'b000_0001_0000,
      ST_SWAP2     = 11'b000_0010_0000,
      ST_REV_CHK   = 11'b000_0100_0000,
      ST_REV_W1    = 11'b000_1000_0000,
      ST_REV_W2    = 11'b001_0000_0000,
      ST_EMIT_RD   = 11'b010_0000_0000,
      ST_EMIT_SHOW = 11'b100_0000_0000
   } state_type;

endpackage

`default_nettype wire

FILE: src/npe_if.sv
`default_nettype none

interface npe_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [npe_pkg::DATA_W-1:0]   value;
   logic                                last;

   modport source (output valid, output value, output last, input ready);
   modport sink (input valid, input value, input last, output ready);
endinterface

interface npe_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [npe_pkg::DATA_W-1:0]   element;
   logic                                found;
   logic                                overflow;
   logic                                end_of_run;

   modport source (output valid, output element, output found, output overflow,
                   output end_of_run, input ready);
   modport sink (input valid, input element, input found, input overflow,
                 input end_of_run, output ready);
endinterface

`default_nettype wire

FILE: src/next_permutation_engine.sv
// next_permutation_engine: rearranges a loaded sequence into its next
// lexicographic permutation (signed compare) and streams it back out.
//
// req_chan: one transaction per element (value, last). last closes the
//   sequence. Elements beyond MAX_ELEMENTS are dropped and the run is flagged
//   with overflow; a dropped element marked last still closes the sequence.
// rsp_chan: one transaction per stored element in index order, each with
//   found (a next permutation existed; else the sequence is unchanged),
//   overflow and end_of_run on the final element.
// steps: loading stores each accepted element. After the closing element the
//   sequencer works on the element memory (two read ports, one write port,
//   registered read data): a read and a compare per position in the ascent
//   scan and in the search for the swap partner, a second write for the swap,
//   a read and two writes per pair in the tail reversal plus a final check,
//   then a read and a show per emitted element.
// req_chan.ready is high only while loading; one sequence is in work at a time.
// a stalled receiver holds the current transaction; the sequencer waits.
// reset (synchronous) empties the block and clears the overflow flag; the
//   element memory is not cleared, only written entries are ever read.
`default_nettype none

module next_permutation_engine #(
   parameter int MAX_ELEMENTS = 8
) (
   input  wire     clock,
   input  wire     reset,
   npe_req_if.sink   req_chan,
   npe_rsp_if.source rsp_chan
);

   localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int CW = $clog2(MAX_ELEMENTS + 1);
   localparam int DW = npe_pkg::DATA_W;

   // sequencer registers
   npe_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;     // stored elements
   logic               ovf_ff, ovf_in;         // elements dropped this run
   logic               found_ff, found_in;
   logic [AW-1:0]      pos_ff, pos_in;         // scan index / low end / emit index
   logic [AW-1:0]      hi_ff, hi_in;           // high end of the reversal
   logic [AW-1:0]      p_ff, p_in;             // ascent position
   logic signed [DW-1:0] vp_ff, vp_in;         // value at the ascent position

   // element memory
   logic signed [DW-1:0] store_mem [MAX_ELEMENTS];
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic signed [DW-1:0] wr_data;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr_a, rd_addr_b;
   logic signed [DW-1:0] rd_a_ff, rd_b_ff;

   logic [AW-1:0] last_idx;
   logic          req_fire;
   logic          room;

   assign last_idx = AW'(count_ff - CW'(1));
   assign room     = (count_ff < CW'(MAX_ELEMENTS));

   assign req_chan.ready = (state_ff == npe_pkg::ST_LOAD);
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid      = (state_ff == npe_pkg::ST_EMIT_SHOW);
   assign rsp_chan.element    = rd_a_ff;
   assign rsp_chan.found      = found_ff;
   assign rsp_chan.overflow   = ovf_ff;
   assign rsp_chan.end_of_run = (pos_ff == last_idx);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read, so it doubles as the swap buffer
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= store_mem[rd_addr_a];
         rd_b_ff <= store_mem[rd_addr_b];
      end
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      found_in  = found_ff;
      pos_in    = pos_ff;
      hi_in     = hi_ff;
      p_in      = p_ff;
      vp_in     = vp_ff;
      wr_en     = 1'b0;
      wr_addr   = pos_ff;
      wr_data   = rd_a_ff;
      rd_en     = 1'b0;
      rd_addr_a = pos_ff;
      rd_addr_b = hi_ff;

      case (state_ff)
         npe_pkg::ST_LOAD: begin
            if (req_fire) begin
               if (room) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[AW-1:0];
                  wr_data  = req_chan.value;
                  count_in = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_chan.last) begin
                  pos_in   = AW'(count_in - CW'(1));
                  state_in = npe_pkg::ST_ASC_RD;
               end
            end
         end
         // look at the pair (pos-1, pos), scanning from the right
         npe_pkg::ST_ASC_RD: begin
            if (count_ff < CW'(2)) begin
               found_in = 1'b0;
               pos_in   = '0;
               state_in = npe_pkg::ST_EMIT_RD;
            end else begin
               rd_en     = 1'b1;
               rd_addr_a = pos_ff;
               rd_addr_b = pos_ff - AW'(1);
               state_in  = npe_pkg::ST_ASC_CMP;
            end
         end
         npe_pkg::ST_ASC_CMP: begin
            if (rd_a_ff > rd_b_ff) begin
               p_in     = pos_ff - AW'(1);
               vp_in    = rd_b_ff;
               pos_in   = last_idx;
               state_in = npe_pkg::ST_J_RD;
            end else if (pos_ff == AW'(1)) begin
               // non-increasing: no next permutation
               found_in = 1'b0;
               pos_in   = '0;
               state_in = npe_pkg::ST_EMIT_RD;
            end else begin
               pos_in   = pos_ff - AW'(1);
               state_in = npe_pkg::ST_ASC_RD;
            end
         end
         // rightmost element greater than the ascent value
         npe_pkg::ST_J_RD: begin
            rd_en     = 1'b1;
            rd_addr_a = pos_ff;
            state_in  = npe_pkg::ST_J_CMP;
         end
         npe_pkg::ST_J_CMP: begin
            if (rd_a_ff > vp_ff) begin
               wr_en    = 1'b1;
               wr_addr  = p_ff;
               wr_data  = rd_a_ff;
               state_in = npe_pkg::ST_SWAP2;
            end else begin
               pos_in   = pos_ff - AW'(1);
               state_in = npe_pkg::ST_J_RD;
            end
         end
         npe_pkg::ST_SWAP2: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff;
            wr_data  = vp_ff;
            found_in = 1'b1;
            pos_in   = p_ff + AW'(1);
            hi_in    = last_idx;
            state_in = npe_pkg::ST_REV_CHK;
         end
         // reverse the tail one pair at a time
         npe_pkg::ST_REV_CHK: begin
            if (pos_ff < hi_ff) begin
               rd_en     = 1'b1;
               rd_addr_a = pos_ff;
               rd_addr_b = hi_ff;
               state_in  = npe_pkg::ST_REV_W1;
            end else begin
               pos_in   = '0;
               state_in = npe_pkg::ST_EMIT_RD;
            end
         end
         npe_pkg::ST_REV_W1: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff;
            wr_data  = rd_b_ff;
            state_in = npe_pkg::ST_REV_W2;
         end
         npe_pkg::ST_REV_W2: begin
            wr_en    = 1'b1;
            wr_addr  = hi_ff;
            wr_data  = rd_a_ff;
            pos_in   = pos_ff + AW'(1);
            hi_in    = hi_ff - AW'(1);
            state_in = npe_pkg::ST_REV_CHK;
         end
         npe_pkg::ST_EMIT_RD: begin
            rd_en     = 1'b1;
            rd_addr_a = pos_ff;
            state_in  = npe_pkg::ST_EMIT_SHOW;
         end
         npe_pkg::ST_EMIT_SHOW: begin
            if (rsp_chan.ready) begin
               if (pos_ff == last_idx) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = npe_pkg::ST_LOAD;
               end else begin
                  pos_in   = pos_ff + AW'(1);
                  state_in = npe_pkg::ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = npe_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= npe_pkg::ST_LOAD;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         found_ff <= found_in;
      end
   end

   // indexes and scan value
   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      hi_ff  <= hi_in;
      p_ff   <= p_in;
      vp_ff  <= vp_in;
   end

endmodule

`default_nettype wire

FILE: src/npe_checker.sv
`default_nettype none

module npe_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_valid,
   input wire                          req_ready,
   input wire                          rsp_valid,
   input wire                          rsp_ready,
   input wire [npe_pkg::DATA_W-1:0]    rsp_element,
   input wire                          rsp_end_of_run
);

   // a stalled transaction holds its element
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_element))
      else $error("rsp element changed while stalled");

   // loading and emitting never overlap
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("req ready while rsp valid");

   // the end of a run hands control back to loading
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_end_of_run |=> req_ready && !rsp_valid)
      else $error("not ready after end of run");

   // reset leaves nothing to emit
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // an accepted element is never followed at once by a transaction out
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid)
      else $error("rsp valid right after load");

endmodule

bind next_permutation_engine npe_checker u_npe_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_element    (rsp_chan.element),
   .rsp_end_of_run (rsp_chan.end_of_run)
);

`default_nettype wire
